// ===== hdl/tpc_pkg.sv =====
// tpc_pkg: types, widths and codes shared by the triangle plane clipper.
// Depends on nothing; every other file of the block refers to it.
package tpc_pkg;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // widths of the fixed-point datapath
    localparam int CRD_W     = 32;               // Q16.16 coordinate
    localparam int PROD_W    = 64;               // coordinate times normal
    localparam int DIST_W    = 67;               // signed distance, exact
    localparam int DMAG_W    = 66;               // magnitude of a nonnegative distance
    localparam int DEN_W     = 68;               // d(I) - d(O), always positive
    localparam int MAG_W     = 33;               // |O - I|
    localparam int CHUNK_W   = 22;               // distance bits per multiply step
    localparam int MUL_STEPS = DMAG_W / CHUNK_W;
    localparam int NUM_W     = DMAG_W + MAG_W;   // d(I) * |O - I|
    localparam int QUO_W     = MAG_W;            // quotient stays below |O - I|
    localparam int WORD_W    = 16;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_POINT_X  = 3'd0;
    localparam logic [2:0] CFG_POINT_Y  = 3'd1;
    localparam logic [2:0] CFG_POINT_Z  = 3'd2;
    localparam logic [2:0] CFG_NORMAL_X = 3'd3;
    localparam logic [2:0] CFG_NORMAL_Y = 3'd4;
    localparam logic [2:0] CFG_NORMAL_Z = 3'd5;

    localparam logic signed [CRD_W-1:0] RST_POINT_Z  = 32'sd6554;
    localparam logic signed [CRD_W-1:0] RST_NORMAL_Z = 32'sd65536;

    typedef struct packed {
        logic signed [CRD_W-1:0]  in_a_x;
        logic signed [CRD_W-1:0]  in_a_y;
        logic signed [CRD_W-1:0]  in_a_z;
        logic signed [CRD_W-1:0]  in_b_x;
        logic signed [CRD_W-1:0]  in_b_y;
        logic signed [CRD_W-1:0]  in_b_z;
        logic signed [CRD_W-1:0]  in_c_x;
        logic signed [CRD_W-1:0]  in_c_y;
        logic signed [CRD_W-1:0]  in_c_z;
        logic        [WORD_W-1:0] in_colour;
        logic        [WORD_W-1:0] in_symbol;
    } t_tri_in;

    typedef struct packed {
        logic signed [CRD_W-1:0]  out_a_x;
        logic signed [CRD_W-1:0]  out_a_y;
        logic signed [CRD_W-1:0]  out_a_z;
        logic signed [CRD_W-1:0]  out_b_x;
        logic signed [CRD_W-1:0]  out_b_y;
        logic signed [CRD_W-1:0]  out_b_z;
        logic signed [CRD_W-1:0]  out_c_x;
        logic signed [CRD_W-1:0]  out_c_y;
        logic signed [CRD_W-1:0]  out_c_z;
        logic        [WORD_W-1:0] out_colour;
        logic        [WORD_W-1:0] out_symbol;
        logic                     last_of_run;
    } t_tri_out;

    // one classified triangle, front to back
    typedef struct packed {
        logic [2:0][2:0][CRD_W-1:0] vtx;    // [vertex][x,y,z]
        logic [2:0][DIST_W-1:0]     sdist;  // signed distance of each vertex
        logic [WORD_W-1:0]          colour;
        logic [WORD_W-1:0]          symbol;
    } t_qent;

    // operands of one cut coordinate
    typedef struct packed {
        logic [DIST_W-1:0] d_in;
        logic [DIST_W-1:0] d_out;
        logic [CRD_W-1:0]  v_in;
        logic [CRD_W-1:0]  v_out;
    } t_cut_req;

    typedef enum logic [1:0] {
        C_IDLE,
        C_MUL,
        C_DIV,
        C_DONE
    } t_cut_st;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CUT,
        B_OUT1,
        B_OUT2
    } t_back_st;

endpackage

// ===== hdl/triangle_plane_clipper_core.sv =====
// triangle_plane_clipper_core: top level of the triangle plane clipper.
// Depends on tpc_pkg, tpc_front, tpc_queue, tpc_back (and tpc_cut_div).
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries one triangle per item
//   (three Q16.16 vertices, colour and symbol). Output channel
//   o_out_valid/i_out_ready carries result triangles, last_of_run set on
//   the final one for each input. A triangle with no vertex inside yields
//   nothing, all inside passes through, one inside gives one triangle and
//   two inside give two.
//   The plane (point and inward normal) is written through i_cfg_we,
//   i_cfg_index and i_cfg_data while the block is idle.
// Timing and overlap:
//   Two distance stages, the queue, the back's working register and the
//   output register lie between acceptance and o_out_valid for a
//   pass-through triangle. Culled triangles are dropped at one per cycle
//   while the back is idle; the back emits a pass-through triangle before
//   it takes the next. A clipped triangle needs six cut coordinates on one
//   shared multiply/divide unit (load, 3 multiply steps, 33 divide steps,
//   done each); the back takes no new triangle until its results are out.
//   The front keeps accepting into the queue while the back works.
// Reset: synchronous active-low; the plane returns to z = 0.1 with normal +z
//   and all pipeline and queue contents are dropped.
// Stall: a stalled receiver holds the output register; the back, then the
//   queue and front fill up and o_in_ready falls.
module triangle_plane_clipper_core #(
    parameter int QUEUE_DEPTH = tpc_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tpc_pkg::t_tri_in   i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tpc_pkg::t_tri_out  o_out_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    logic           w_f_valid, w_f_ready;
    tpc_pkg::t_qent w_f_ent;
    logic           w_q_valid, w_q_ready;
    tpc_pkg::t_qent w_q_ent;

    tpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ent_valid (w_f_valid),
        .i_ent_ready (w_f_ready),
        .o_ent       (w_f_ent)
    );

    tpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_data  (w_f_ent),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_data   (w_q_ent)
    );

    tpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_ready   (w_q_ready),
        .i_q_data    (w_q_ent),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hdl/tpc_front.sv =====
// tpc_front: plane registers and the two-stage distance pipeline.
// Depends on tpc_pkg; feeds classified triangles to tpc_queue.
module tpc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tpc_pkg::t_tri_in   i_in_data,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_ent_valid,
    input  logic               i_ent_ready,
    output tpc_pkg::t_qent     o_ent
);

    logic signed [tpc_pkg::CRD_W-1:0] r_pt [3];
    logic signed [tpc_pkg::CRD_W-1:0] r_nm [3];

    // plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt[0] <= '0;
            r_pt[1] <= '0;
            r_pt[2] <= tpc_pkg::RST_POINT_Z;
            r_nm[0] <= '0;
            r_nm[1] <= '0;
            r_nm[2] <= tpc_pkg::RST_NORMAL_Z;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tpc_pkg::CFG_POINT_X:  r_pt[0] <= i_cfg_data;
                tpc_pkg::CFG_POINT_Y:  r_pt[1] <= i_cfg_data;
                tpc_pkg::CFG_POINT_Z:  r_pt[2] <= i_cfg_data;
                tpc_pkg::CFG_NORMAL_X: r_nm[0] <= i_cfg_data;
                tpc_pkg::CFG_NORMAL_Y: r_nm[1] <= i_cfg_data;
                tpc_pkg::CFG_NORMAL_Z: r_nm[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [tpc_pkg::CRD_W-1:0] w_v [3][3];
    assign w_v[0][0] = i_in_data.in_a_x;
    assign w_v[0][1] = i_in_data.in_a_y;
    assign w_v[0][2] = i_in_data.in_a_z;
    assign w_v[1][0] = i_in_data.in_b_x;
    assign w_v[1][1] = i_in_data.in_b_y;
    assign w_v[1][2] = i_in_data.in_b_z;
    assign w_v[2][0] = i_in_data.in_c_x;
    assign w_v[2][1] = i_in_data.in_c_y;
    assign w_v[2][2] = i_in_data.in_c_z;

    logic w_adv2;
    logic r_s1_v, r_s2_v;
    logic signed [tpc_pkg::PROD_W-1:0] r_prod [3][3];
    logic signed [tpc_pkg::PROD_W-1:0] r_npp  [3];
    logic [2:0][2:0][tpc_pkg::CRD_W-1:0] r_s1_vtx;
    logic [tpc_pkg::WORD_W-1:0] r_s1_col, r_s1_sym;
    tpc_pkg::t_qent r_s2;

    assign w_adv2      = !r_s2_v || i_ent_ready;
    assign o_in_ready  = w_adv2 || !r_s1_v;
    assign o_ent_valid = r_s2_v;
    assign o_ent       = r_s2;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_v <= i_in_valid;
            end
            if (w_adv2) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    // stage 1: products of normal with vertices and with plane point
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            for (int k = 0; k < 3; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_prod[k][c]   <= r_nm[c] * w_v[k][c];
                    r_s1_vtx[k][c] <= w_v[k][c];
                end
                r_npp[k] <= r_nm[k] * r_pt[k];
            end
            r_s1_col <= i_in_data.in_colour;
            r_s1_sym <= i_in_data.in_symbol;
        end
    end

    // stage 2: exact signed distances
    logic signed [tpc_pkg::DIST_W-1:0] w_np;
    logic signed [tpc_pkg::DIST_W-1:0] w_d [3];

    always_comb begin
        w_np = tpc_pkg::DIST_W'(r_npp[0]) + tpc_pkg::DIST_W'(r_npp[1])
             + tpc_pkg::DIST_W'(r_npp[2]);
        for (int k = 0; k < 3; k++) begin
            w_d[k] = tpc_pkg::DIST_W'(r_prod[k][0]) + tpc_pkg::DIST_W'(r_prod[k][1])
                   + tpc_pkg::DIST_W'(r_prod[k][2]) - w_np;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2 && r_s1_v) begin
            r_s2.vtx    <= r_s1_vtx;
            r_s2.colour <= r_s1_col;
            r_s2.symbol <= r_s1_sym;
            for (int k = 0; k < 3; k++) begin
                r_s2.sdist[k] <= w_d[k];
            end
        end
    end

endmodule

// ===== hdl/tpc_queue.sv =====
// tpc_queue: short register queue between the front and back halves.
// Depends on tpc_pkg for the entry type.
module tpc_queue #(
    parameter int DEPTH = tpc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  tpc_pkg::t_qent i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output tpc_pkg::t_qent o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tpc_pkg::t_qent   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== hdl/tpc_cut_div.sv =====
// tpc_cut_div: one cut coordinate, I + sign * floor(|O-I| * d(I) / (d(I)-d(O))).
// Depends on tpc_pkg; a shift-add multiply followed by a restoring divider.
module tpc_cut_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  tpc_pkg::t_cut_req         i_req,
    output logic                      o_done,
    output logic [tpc_pkg::CRD_W-1:0] o_res
);

    tpc_pkg::t_cut_st r_st, n_st;
    logic [5:0] r_cnt;

    logic [tpc_pkg::DMAG_W-1:0] r_dim;
    logic [tpc_pkg::MAG_W-1:0]  r_m;
    logic [tpc_pkg::DEN_W-1:0]  r_den;
    logic [tpc_pkg::NUM_W-1:0]  r_num;
    logic [tpc_pkg::DEN_W-1:0]  r_rem;
    logic [tpc_pkg::QUO_W-1:0]  r_lo;
    logic [tpc_pkg::QUO_W-1:0]  r_q;
    logic [tpc_pkg::CRD_W-1:0]  r_vin;
    logic [tpc_pkg::CRD_W-1:0]  r_res;
    logic                       r_neg;

    // operand setup
    logic signed [tpc_pkg::MAG_W-1:0] w_diff;
    logic [tpc_pkg::DEN_W-1:0]        w_den;
    assign w_diff = tpc_pkg::MAG_W'($signed(i_req.v_out))
                  - tpc_pkg::MAG_W'($signed(i_req.v_in));
    assign w_den  = tpc_pkg::DEN_W'($signed(i_req.d_in))
                  - tpc_pkg::DEN_W'($signed(i_req.d_out));

    // one multiply step: top chunk of the distance times the magnitude
    logic [tpc_pkg::CHUNK_W+tpc_pkg::MAG_W-1:0] w_part;
    logic [tpc_pkg::NUM_W-1:0]                  w_num;
    assign w_part = r_dim[tpc_pkg::DMAG_W-1 -: tpc_pkg::CHUNK_W] * r_m;
    assign w_num  = (r_num << tpc_pkg::CHUNK_W) + tpc_pkg::NUM_W'(w_part);

    // one divide step
    logic [tpc_pkg::DEN_W-1:0] w_trial;
    logic                      w_ge;
    logic [tpc_pkg::QUO_W-1:0] w_q;
    assign w_trial = {r_rem[tpc_pkg::DEN_W-2:0], r_lo[tpc_pkg::QUO_W-1]};
    assign w_ge    = (w_trial >= r_den);
    assign w_q     = {r_q[tpc_pkg::QUO_W-2:0], w_ge};

    assign o_done = (r_st == tpc_pkg::C_DONE);
    assign o_res  = r_res;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tpc_pkg::C_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            tpc_pkg::C_IDLE: if (i_start) n_st = tpc_pkg::C_MUL;
            tpc_pkg::C_MUL:  if (r_cnt == 6'(tpc_pkg::MUL_STEPS - 1)) n_st = tpc_pkg::C_DIV;
            tpc_pkg::C_DIV:  if (r_cnt == 6'(tpc_pkg::QUO_W - 1)) n_st = tpc_pkg::C_DONE;
            tpc_pkg::C_DONE: n_st = tpc_pkg::C_IDLE;
            default:         n_st = tpc_pkg::C_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            tpc_pkg::C_IDLE: begin
                r_cnt <= '0;
                r_num <= '0;
                r_dim <= i_req.d_in[tpc_pkg::DMAG_W-1:0];
                r_den <= w_den;
                r_vin <= i_req.v_in;
                r_neg <= w_diff[tpc_pkg::MAG_W-1];
                r_m   <= w_diff[tpc_pkg::MAG_W-1] ? -w_diff : w_diff;
            end
            tpc_pkg::C_MUL: begin
                r_num <= w_num;
                r_dim <= r_dim << tpc_pkg::CHUNK_W;
                if (r_cnt == 6'(tpc_pkg::MUL_STEPS - 1)) begin
                    // quotient fits QUO_W bits, so the high part is below the divisor
                    r_rem <= tpc_pkg::DEN_W'(w_num[tpc_pkg::NUM_W-1:tpc_pkg::QUO_W]);
                    r_lo  <= w_num[tpc_pkg::QUO_W-1:0];
                    r_q   <= '0;
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            tpc_pkg::C_DIV: begin
                r_rem <= w_ge ? w_trial - r_den : w_trial;
                r_lo  <= r_lo << 1;
                r_q   <= w_q;
                r_cnt <= r_cnt + 1'b1;
                r_res <= r_neg ? r_vin - w_q[tpc_pkg::CRD_W-1:0]
                               : r_vin + w_q[tpc_pkg::CRD_W-1:0];
            end
            tpc_pkg::C_DONE: ;
            default: ;
        endcase
    end

endmodule

// ===== hdl/tpc_back.sv =====
// tpc_back: takes classified triangles, sequences the cuts and emits results.
// Depends on tpc_pkg and tpc_cut_div; holds the output register.
module tpc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_ready,
    input  tpc_pkg::t_qent     i_q_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tpc_pkg::t_tri_out  o_out_data
);

    typedef logic [2:0][tpc_pkg::CRD_W-1:0] t_vert;

    tpc_pkg::t_back_st r_st, n_st;
    tpc_pkg::t_qent    r_w;
    logic [1:0][2:0][tpc_pkg::CRD_W-1:0] r_x;   // [cut][x,y,z]
    logic [2:0]        r_j;
    logic              r_started;
    logic              r_o_v;
    tpc_pkg::t_tri_out r_o;

    // inside count from the sign bits
    function automatic logic [1:0] f_ni(input logic [2:0] s);
        return 2'd3 - 2'($countones(s));
    endfunction

    function automatic tpc_pkg::t_tri_out f_tri(input t_vert a, input t_vert b,
                                                input t_vert c, input logic [15:0] col,
                                                input logic [15:0] sym, input logic last);
        tpc_pkg::t_tri_out t;
        t.out_a_x = a[0]; t.out_a_y = a[1]; t.out_a_z = a[2];
        t.out_b_x = b[0]; t.out_b_y = b[1]; t.out_b_z = b[2];
        t.out_c_x = c[0]; t.out_c_y = c[1]; t.out_c_z = c[2];
        t.out_colour  = col;
        t.out_symbol  = sym;
        t.last_of_run = last;
        return t;
    endfunction

    logic [2:0] w_s, w_qs;      // 1 = outside
    logic [1:0] w_ni;
    logic [1:0] w_ins0, w_ins1, w_outs0, w_outs1;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_s[k]  = r_w.sdist[k][tpc_pkg::DIST_W-1];
            w_qs[k] = i_q_data.sdist[k][tpc_pkg::DIST_W-1];
        end
        w_ni    = f_ni(w_s);
        w_ins0  = !w_s[0] ? 2'd0 : (!w_s[1] ? 2'd1 : 2'd2);
        w_ins1  = w_s[0]  ? 2'd2 : (!w_s[1] ? 2'd1 : 2'd2);
        w_outs0 = w_s[0]  ? 2'd0 : (w_s[1] ? 2'd1 : 2'd2);
        w_outs1 = !w_s[0] ? 2'd2 : (w_s[1] ? 2'd1 : 2'd2);
    end

    // operands of the current cut coordinate
    logic       w_pair;
    logic [1:0] w_c, w_iv, w_ov;
    tpc_pkg::t_cut_req w_req;
    logic       w_start, w_done;
    logic [tpc_pkg::CRD_W-1:0] w_res;

    always_comb begin
        w_pair = (r_j >= 3'd3);
        w_c    = w_pair ? 2'(r_j - 3'd3) : r_j[1:0];
        w_iv   = (w_pair && w_ni == 2'd2) ? w_ins1 : w_ins0;
        w_ov   = (w_pair && w_ni == 2'd1) ? w_outs1 : w_outs0;
        w_req.d_in  = r_w.sdist[w_iv];
        w_req.d_out = r_w.sdist[w_ov];
        w_req.v_in  = r_w.vtx[w_iv][w_c];
        w_req.v_out = r_w.vtx[w_ov][w_c];
    end

    tpc_cut_div u_cut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // sequencer
    logic              w_out_free, w_load;
    tpc_pkg::t_tri_out w_tri;

    assign w_out_free  = !r_o_v || i_out_ready;
    assign o_out_valid = r_o_v;
    assign o_out_data  = r_o;

    always_comb begin
        n_st      = r_st;
        o_q_ready = 1'b0;
        w_start   = 1'b0;
        w_load    = 1'b0;
        w_tri     = f_tri(r_w.vtx[w_ins1], r_x[0], r_x[1], r_w.colour, r_w.symbol, 1'b1);
        unique case (r_st)
            tpc_pkg::B_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    priority case (f_ni(w_qs))
                        2'd0:    n_st = tpc_pkg::B_IDLE;
                        2'd3:    n_st = tpc_pkg::B_OUT1;
                        default: n_st = tpc_pkg::B_CUT;
                    endcase
                end
            end
            tpc_pkg::B_CUT: begin
                w_start = !r_started;
                if (w_done && r_j == 3'd5) n_st = tpc_pkg::B_OUT1;
            end
            tpc_pkg::B_OUT1: begin
                w_load = w_out_free;
                priority case (w_ni)
                    2'd3: w_tri = f_tri(r_w.vtx[0], r_w.vtx[1], r_w.vtx[2],
                                        r_w.colour, r_w.symbol, 1'b1);
                    2'd1: w_tri = f_tri(r_w.vtx[w_ins0], r_x[0], r_x[1],
                                        r_w.colour, r_w.symbol, 1'b1);
                    default: w_tri = f_tri(r_w.vtx[w_ins0], r_w.vtx[w_ins1], r_x[0],
                                           r_w.colour, r_w.symbol, 1'b0);
                endcase
                if (w_out_free) n_st = (w_ni == 2'd2) ? tpc_pkg::B_OUT2 : tpc_pkg::B_IDLE;
            end
            tpc_pkg::B_OUT2: begin
                w_load = w_out_free;
                if (w_out_free) n_st = tpc_pkg::B_IDLE;
            end
            default: n_st = tpc_pkg::B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= tpc_pkg::B_IDLE;
            r_j       <= '0;
            r_started <= 1'b0;
            r_o_v     <= 1'b0;
        end else begin
            r_st <= n_st;
            if (o_q_ready && i_q_valid) begin
                r_j       <= '0;
                r_started <= 1'b0;
            end else if (w_done) begin
                r_j       <= r_j + 1'b1;
                r_started <= 1'b0;
            end else if (w_start) begin
                r_started <= 1'b1;
            end
            if (w_load) begin
                r_o_v <= 1'b1;
            end else if (i_out_ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_q_ready && i_q_valid) begin
            r_w <= i_q_data;
        end
        if (w_done) begin
            r_x[w_pair][w_c] <= w_res;
        end
        if (w_load) begin
            r_o <= w_tri;
        end
    end

    // a cut result only comes back while a cut is in flight
    a_done_in_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_st == tpc_pkg::B_CUT) && r_started)
        else $error("cut result outside of cut sequence");

    // a new triangle is taken only when the previous one is finished
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_ready && i_q_valid) |-> (r_st == tpc_pkg::B_IDLE))
        else $error("queue popped while busy");

    // the coordinate counter never passes the last cut coordinate
    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == tpc_pkg::B_CUT) |-> (r_j <= 3'd5))
        else $error("cut coordinate counter out of range");

    // a non-final result is only the first of a split triangle
    a_first_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !w_tri.last_of_run) |=> (r_st == tpc_pkg::B_OUT2))
        else $error("first of two results not followed by the second");

endmodule
